// ----- rtl/lia_pkg.sv -----
package lia_pkg;

	// Largest line length the design is built for, and its default.
	localparam int LIA_MAX_CHARS_HIGH = 62;
	localparam int LIA_MAX_CHARS      = 62;

	// Width of a character count that can hold the largest line length.
	localparam int CNT_W  = $clog2(LIA_MAX_CHARS_HIGH + 1);
	localparam int CHAR_W = 7;
	localparam int BYTE_W = 8;

	// Depth of the operation queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Byte codes with a special meaning.
	localparam logic [BYTE_W-1:0] BYTE_BS        = 8'd8;
	localparam logic [BYTE_W-1:0] BYTE_LF        = 8'd10;
	localparam logic [BYTE_W-1:0] BYTE_CR        = 8'd13;
	localparam logic [BYTE_W-1:0] BYTE_PRINT_LO  = 8'd32;
	localparam logic [BYTE_W-1:0] BYTE_PRINT_HI  = 8'd126;

	// Operations handed from the front to the back.
	typedef enum logic {
		OP_APPEND,
		OP_EMIT
	} lia_op_kind_t;

	// An append carries the character and its slot; an emit carries the line length.
	typedef struct packed {
		lia_op_kind_t      kind;
		logic [CHAR_W-1:0] ch;
		logic [CNT_W-1:0]  num;
	} lia_op_t;

endpackage

// ----- rtl/lia_ram.sv -----
module lia_ram #(
	parameter int WIDTH = 7,
	parameter int DEPTH = 62
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port; read data holds while not enabled.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- rtl/lia_front.sv -----
module lia_front #(
	parameter int MAX_LINE_CHARS = 62
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [lia_pkg::BYTE_W-1:0]     rx_byte,
	input  logic                           in_valid,
	output logic                           in_ready,
	output logic                           op_push,
	output lia_pkg::lia_op_t               op,
	input  logic                           op_full
);

	import lia_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;
	logic             disc_q;
	logic             disc_d;
	logic             accept;
	logic             is_newline;
	logic             is_print;
	logic             line_full;

	// A request is taken whenever the queue has room for the operation it may cause.
	assign in_ready = !op_full;
	assign accept   = in_valid && in_ready;

	// Byte classification.
	assign is_newline = (rx_byte == BYTE_LF) || (rx_byte == BYTE_CR);
	assign is_print   = (rx_byte >= BYTE_PRINT_LO) && (rx_byte <= BYTE_PRINT_HI);
	assign line_full  = (cnt_q >= CNT_W'(MAX_LINE_CHARS));

	// Decide the operation for the accepted byte and track the line length.
	always_comb begin
		op_push = 1'b0;
		op.kind = OP_APPEND;
		op.ch   = rx_byte[CHAR_W-1:0];
		op.num  = cnt_q;
		cnt_d   = cnt_q;
		disc_d  = disc_q;
		if (accept) begin
			priority if (disc_q) begin
				if (is_newline) begin
					disc_d = 1'b0;
				end
			end else if (is_newline) begin
				if (cnt_q != '0) begin
					op_push = 1'b1;
					op.kind = OP_EMIT;
				end
				cnt_d = '0;
			end else if (line_full) begin
				// Overlong line: send what is held and skip up to the next newline.
				op_push = 1'b1;
				op.kind = OP_EMIT;
				cnt_d   = '0;
				disc_d  = 1'b1;
			end else if (rx_byte == BYTE_BS) begin
				if (cnt_q != '0) begin
					cnt_d = cnt_q - CNT_W'(1);
				end
			end else if (is_print) begin
				op_push = 1'b1;
				cnt_d   = cnt_q + CNT_W'(1);
			end else begin
				// Control and non-ASCII bytes are dropped.
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			disc_q <= 1'b0;
		end else begin
			cnt_q  <= cnt_d;
			disc_q <= disc_d;
		end
	end

endmodule

// ----- rtl/lia_fifo.sv -----
module lia_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lia_pkg::lia_op_t push_op,
	output logic             full,
	input  logic             pop,
	output lia_pkg::lia_op_t head_op,
	output logic             not_empty
);

	import lia_pkg::*;

	lia_op_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QPTR_W:0]    fill_q;

	assign full      = (fill_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign not_empty = (fill_q != '0);
	assign head_op   = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (QPTR_W + 1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (QPTR_W + 1)'(1);
			end
		end
	end

endmodule

// ----- rtl/lia_back.sv -----
module lia_back #(
	parameter int MAX_LINE_CHARS = 62
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           op_valid,
	input  lia_pkg::lia_op_t               op,
	output logic                           op_pop,
	output logic [lia_pkg::CHAR_W-1:0]     line_char,
	output logic                           line_last,
	output logic                           out_valid,
	input  logic                           out_ready
);

	import lia_pkg::*;

	localparam int AW = (MAX_LINE_CHARS > 1) ? $clog2(MAX_LINE_CHARS) : 1;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] len_q;
	logic [CNT_W-1:0] idx_q;
	logic             out_valid_q;
	logic             last_q;
	logic             rd_en;
	logic             wr_en;
	logic             rd_is_last;

	// Operations are taken in order; an emit blocks the queue until its line is read out.
	assign op_pop     = (state_q == ST_IDLE) && op_valid;
	assign wr_en      = op_pop && (op.kind == OP_APPEND);
	assign rd_en      = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign rd_is_last = (idx_q == (len_q - CNT_W'(1)));

	lia_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (MAX_LINE_CHARS)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (op.num[AW-1:0]),
		.wr_data (op.ch),
		.rd_en   (rd_en),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (line_char)
	);

	assign out_valid = out_valid_q;
	assign line_last = last_q;

	// Sequencer for line read-out; the store's read register is the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (rd_en) begin
				out_valid_q <= 1'b1;
				last_q      <= rd_is_last;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (op_pop && (op.kind == OP_EMIT)) begin
						len_q   <= op.num;
						idx_q   <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (rd_en) begin
						idx_q <= idx_q + CNT_W'(1);
						if (rd_is_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/line_input_assembler.sv -----
// Line input assembler.
// The input channel (rx_byte, in_valid, in_ready) takes one received byte per
// request. CR or LF closes the current line, backspace removes the last stored
// character, printable bytes are appended and all other bytes are dropped.
// A line that reaches MAX_LINE_CHARS characters is sent as soon as one more
// non-newline byte arrives, and the rest of it is skipped up to the next newline.
// The output channel (line_char, line_last, out_valid, out_ready) gives one
// character per request, with line_last set on the final character of a line.
// Throughput: one byte per cycle on the input while the operation queue (four
// entries) has room; one character per cycle on the output while out_ready is
// high, read from the line store through its single read port. A closing byte's
// emit is queued, taken by the back end once it is free, and the first character
// is read into the output register. While a line drains, bytes are accepted until
// the queue fills; a stalled receiver holds the output and, when full, in_ready.
// Reset clears the line length, the skip flag, the queue and out_valid; the
// block takes requests in the first cycle after reset.
module line_input_assembler #(
	parameter int MAX_LINE_CHARS = lia_pkg::LIA_MAX_CHARS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [lia_pkg::BYTE_W-1:0]     rx_byte,
	input  logic                           in_valid,
	output logic                           in_ready,
	output logic [lia_pkg::CHAR_W-1:0]     line_char,
	output logic                           line_last,
	output logic                           out_valid,
	input  logic                           out_ready
);

	import lia_pkg::*;

	logic    op_push;
	lia_op_t push_op;
	logic    op_full;
	logic    op_pop;
	lia_op_t head_op;
	logic    op_valid;

	lia_front #(
		.MAX_LINE_CHARS (MAX_LINE_CHARS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_byte  (rx_byte),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op_push  (op_push),
		.op       (push_op),
		.op_full  (op_full)
	);

	lia_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (op_push),
		.push_op   (push_op),
		.full      (op_full),
		.pop       (op_pop),
		.head_op   (head_op),
		.not_empty (op_valid)
	);

	lia_back #(
		.MAX_LINE_CHARS (MAX_LINE_CHARS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op        (head_op),
		.op_pop    (op_pop),
		.line_char (line_char),
		.line_last (line_last),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

endmodule

// ----- rtl/lia_checker.sv -----
module lia_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic [lia_pkg::BYTE_W-1:0]     rx_byte,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic [lia_pkg::CHAR_W-1:0]     line_char,
	input logic                           line_last,
	input logic                           out_valid,
	input logic                           out_ready
);

	import lia_pkg::*;

	// A stalled character holds its value and its last mark.
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(out_valid && !out_ready) |-> out_valid && $stable(line_char) && $stable(line_last))
	else $error("stalled output character changed");

	// Only printable characters leave the block.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (line_char >= BYTE_PRINT_LO[CHAR_W-1:0]) &&
			(line_char <= BYTE_PRINT_HI[CHAR_W-1:0]))
	else $error("non-printable character on the output");

	// Nothing is offered on the output right after reset is released.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
	else $error("output valid right after reset");

	// The input is ready in the first cycle after reset, since the queue is empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> in_ready)
	else $error("input not ready after reset");

endmodule

bind line_input_assembler lia_checker u_lia_checker (.*);

// ----- tb/tb_line_input_assembler.sv -----
module tb_line_input_assembler;
	import lia_pkg::*;

	localparam int LINE_MAX     = LIA_MAX_CHARS;
	localparam int SETTLE_CYCLES = 16;
	localparam int DRAIN_LIMIT   = 50000;

	// One expected output request: a character and its end-of-line mark.
	typedef struct {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} line_res_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic [BYTE_W-1:0] rx_byte   = '0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	logic [CHAR_W-1:0] line_char;
	logic              line_last;
	logic              out_valid;
	logic              out_ready = 1'b0;

	// Shadow of the line being built, used to predict each emitted line.
	logic [CHAR_W-1:0] shadow_line [LINE_MAX];
	int                shadow_len  = 0;
	bit                shadow_skip = 1'b0;

	line_res_t line_chars_due [$];
	int        error_count = 0;
	bit        idle_on     = 1'b0;
	int        hold_left   = 0;
	int        bytes_sent  = 0;

	line_input_assembler #(
		.MAX_LINE_CHARS(LINE_MAX)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_byte  (rx_byte),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.line_char(line_char),
		.line_last(line_last),
		.out_valid(out_valid),
		.out_ready(out_ready)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Queue every held character as an expected request and empty the line.
	function automatic void flush_shadow_line();
		line_res_t r;
		for (int k = 0; k < shadow_len; k++) begin
			r.ch   = shadow_line[k];
			r.last = (k == shadow_len - 1);
			line_chars_due.push_back(r);
		end
		shadow_len = 0;
	endfunction

	// Apply one accepted byte to the shadow line.
	function automatic void note_byte(input logic [BYTE_W-1:0] b);
		bit is_nl;
		is_nl = (b == BYTE_LF) || (b == BYTE_CR);
		if (shadow_skip) begin
			if (is_nl)
				shadow_skip = 1'b0;
		end else if (is_nl) begin
			flush_shadow_line();
		end else if (shadow_len >= LINE_MAX) begin
			// A full line goes out on any further non-newline byte, which is itself dropped.
			shadow_skip = 1'b1;
			flush_shadow_line();
		end else if (b == BYTE_BS) begin
			if (shadow_len > 0)
				shadow_len--;
		end else if (b >= BYTE_PRINT_LO && b <= BYTE_PRINT_HI) begin
			shadow_line[shadow_len] = b[CHAR_W-1:0];
			shadow_len++;
		end
	endfunction

	// A random byte that is neither printable nor newline nor backspace.
	function automatic logic [BYTE_W-1:0] pick_junk();
		logic [BYTE_W-1:0] v;
		do begin
			v = BYTE_W'($urandom_range(0, 255));
		end while ((v >= BYTE_PRINT_LO && v <= BYTE_PRINT_HI) ||
			v == BYTE_BS || v == BYTE_LF || v == BYTE_CR);
		return v;
	endfunction

	// Offer one byte, with an optional gap first, and wait for its request to be taken.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		if (idle_on && $urandom_range(99) < 20) begin
			gap = $urandom_range(1, 4);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		rx_byte  <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		note_byte(b);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_printable_run(input int n);
		for (int i = 0; i < n; i++)
			send_byte(BYTE_W'($urandom_range(BYTE_PRINT_LO, BYTE_PRINT_HI)));
	endtask

	// Stop offering bytes until every expected request has come out or the drain limit is reached, then settle.
	task automatic wait_drain();
		int n;
		n = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (line_chars_due.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Short lines, blank lines, backspace and dropped bytes.
	task automatic test_basic_lines();
		idle_on = 1'b0;
		send_text("AB");
		send_byte(BYTE_CR);
		send_byte(BYTE_LF);
		send_byte(BYTE_LF);
		send_byte(BYTE_BS);
		send_text("x");
		send_byte(BYTE_BS);
		send_text("yz");
		send_byte(BYTE_LF);
		send_byte(BYTE_PRINT_LO);
		send_byte(BYTE_PRINT_HI);
		send_byte(8'd0);
		send_byte(8'd31);
		send_byte(8'd127);
		send_byte(8'd128);
		send_byte(8'd255);
		send_byte(8'd9);
		send_byte(BYTE_CR);
		wait_drain();
	endtask

	// Lines that reach the length limit, and the skip that follows an overflow.
	task automatic test_full_line();
		idle_on = 1'b1;
		send_printable_run(LINE_MAX);
		send_byte(BYTE_BS);
		send_text("q");
		send_byte(8'd200);
		send_byte(BYTE_CR);
		send_byte(BYTE_LF);
		send_printable_run(LINE_MAX);
		send_byte(BYTE_CR);
		wait_drain();
	endtask

	// Hold the receiver off while lines keep coming, so the input stalls.
	task automatic test_receiver_stall();
		idle_on   = 1'b0;
		hold_left = 300;
		for (int i = 0; i < 8; i++) begin
			send_printable_run($urandom_range(1, 10));
			send_byte(BYTE_LF);
		end
		wait_drain();
	endtask

	// Mostly well-formed lines with random content, plus noise bursts.
	task automatic test_random_lines(input int n_items, input bit with_idle);
		int stop_at;
		int len;
		int r;
		idle_on = with_idle;
		stop_at = bytes_sent + n_items;
		while (bytes_sent < stop_at) begin
			r = $urandom_range(99);
			if (r < 12) begin
				repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom_range(0, 255)));
			end else begin
				if ($urandom_range(9) == 0)
					len = $urandom_range(LINE_MAX - 6, LINE_MAX + 8);
				else
					len = $urandom_range(0, 12);
				for (int i = 0; i < len; i++) begin
					r = $urandom_range(99);
					if (r < 10)
						send_byte(BYTE_BS);
					else if (r < 14)
						send_byte(pick_junk());
					else
						send_byte(BYTE_W'($urandom_range(BYTE_PRINT_LO, BYTE_PRINT_HI)));
				end
				send_byte($urandom_range(1) ? BYTE_CR : BYTE_LF);
				if ($urandom_range(9) == 0)
					send_byte(BYTE_LF);
			end
		end
		wait_drain();
	endtask

	// Receiver: long hold-offs first, then random idling when enabled.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (idle_on) begin
			out_ready <= ($urandom_range(99) >= 20);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Compare each output request with the oldest expected character.
	always @(posedge clk) begin
		line_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (line_chars_due.size() == 0) begin
				$error("unexpected output: line_char %0d line_last %0d",
					line_char, line_last);
				error_count++;
			end else begin
				want = line_chars_due.pop_front();
				if (line_char !== want.ch) begin
					$error("line_char: expected %0d, actual %0d", want.ch, line_char);
					error_count++;
				end
				if (line_last !== want.last) begin
					$error("line_last: expected %0d, actual %0d", want.last, line_last);
					error_count++;
				end
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_basic_lines();
		test_full_line();
		test_receiver_stall();
		test_random_lines(40, 1'b1);
		test_random_lines(20, 1'b0);
		test_random_lines(20, 1'b1);

		if (line_chars_due.size() != 0) begin
			$error("%0d expected characters never came out", line_chars_due.size());
			error_count++;
		end
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#400000;
		$display("status: fail");
		$finish;
	end

endmodule
